/* sv/first_occurrence_string_matcher_defines.svh */
// Assertion macros for the first-occurrence string matcher.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef FIRST_OCCURRENCE_STRING_MATCHER_DEFINES_SVH
`define FIRST_OCCURRENCE_STRING_MATCHER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FOSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fosm check failed");

// Next-cycle implication, checked outside reset
`define FOSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fosm check failed");

`endif

/* sv/fosm_pkg.sv */
// Shared types and constants for the first-occurrence string matcher.
// No dependencies; used by fosm_cell and first_occurrence_string_matcher.
package fosm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int POSITION_BITS   = 20;
  localparam int BYTE_BITS       = 8;

  // Opcodes of an input item
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NONE     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic                 opcode;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 is_last;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [POSITION_BITS-1:0] match_position;
  } res_item_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic wr;     // load pattern byte into this cell
    logic shift;  // advance partial match with current text byte
    logic clr;    // drop partial match
  } cell_ctl_t;

endpackage

/* sv/fosm_cell.sv */
// One position of the shift-and comparator chain: holds a pattern byte and
// its partial-match bit. Depends on fosm_pkg.
module fosm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  fosm_pkg::cell_ctl_t           ctl,
  input  logic [fosm_pkg::BYTE_BITS-1:0] data_byte,
  input  logic                          pm_in,
  output logic                          pm_out,
  output logic                          hit
);

  logic [fosm_pkg::BYTE_BITS-1:0] pat_byte;
  logic                           pm;
  logic                           pm_next;

  // Extend the neighbor's partial match when this byte agrees
  assign hit = pm_in & (pat_byte == data_byte);

  always_comb begin
    pm_next = pm;
    if (ctl.clr) begin
      pm_next = 1'b0;
    end else if (ctl.shift) begin
      pm_next = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm <= 1'b0;
    end else begin
      pm <= pm_next;
    end
  end

  // Hold the pattern byte once loaded
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      pat_byte <= data_byte;
    end
  end

  assign pm_out = pm;

endmodule

/* sv/first_occurrence_string_matcher.sv */
// First-occurrence string matcher: top level with sequencer and cell chain.
// Depends on fosm_pkg, fosm_cell and first_occurrence_string_matcher_defines.svh.
//
// Load a pattern one byte per item (opcode pattern, is_last closes it), then
// stream text bytes (opcode text). Every text byte is compared against all
// pattern positions at once by a row of PATTERN_MAX cells, each passing its
// partial-match bit to the next, so one item is taken every clock cycle with no
// bubbles unless stalled. The result of an item appears in the output register
// on the cycle after it is accepted; the input stalls only while that register
// holds an item the receiver is stalling. At most one result per search: found
// with the start index, none at the last text byte, or overflow when the pattern
// exceeded PATTERN_MAX bytes. Text bytes sent while a pattern is open are dropped.
`include "first_occurrence_string_matcher_defines.svh"

module first_occurrence_string_matcher #(
  parameter int PATTERN_MAX = fosm_pkg::PATTERN_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  fosm_pkg::cmd_item_t cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output fosm_pkg::res_item_t res
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = fosm_pkg::POSITION_BITS;

  // Sequencer state
  logic [LEN_W-1:0] len;
  logic             closed;
  logic             ovf;
  logic [POS_W-1:0] pos;
  logic             done;

  logic             acc;
  logic             is_load;
  logic             is_text;
  logic [LEN_W-1:0] eff_len;
  logic             has_room;
  logic             ovf_new;
  logic             search_live;
  logic             shift;
  logic             clear;
  logic             found;
  logic [POS_W-1:0] found_pos;
  logic             emit;
  fosm_pkg::res_item_t res_new;

  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] pm;
  logic [PATTERN_MAX-1:0] tail;

  // Handshake: stall only while a held result is itself stalled
  assign cmd_stall = res_valid & res_stall;
  assign acc       = cmd_valid & ~cmd_stall;
  assign is_load   = acc & (cmd.opcode == fosm_pkg::OP_PATTERN);
  assign is_text   = acc & (cmd.opcode == fosm_pkg::OP_TEXT) & closed;

  // Pattern loading
  assign eff_len  = closed ? '0 : len;
  assign has_room = eff_len < LEN_W'(PATTERN_MAX);
  assign ovf_new  = (closed ? 1'b0 : ovf) | ~has_room;

  // Search control
  assign search_live = is_text & ~ovf & ~done;
  assign shift       = search_live & (len != '0);
  assign clear       = (is_load | is_text) & cmd.is_last;

  // Cell chain
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    fosm_pkg::cell_ctl_t ctl;
    logic                pm_in;

    assign ctl.wr    = is_load & has_room & (eff_len == LEN_W'(k));
    assign ctl.shift = shift;
    assign ctl.clr   = clear;
    assign tail[k]   = (len == LEN_W'(k + 1));

    if (k == 0) begin : g_head
      assign pm_in = 1'b1;
    end else begin : g_body
      assign pm_in = pm[k-1];
    end

    fosm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .data_byte (cmd.data_byte),
      .pm_in     (pm_in),
      .pm_out    (pm[k]),
      .hit       (hit[k])
    );
  end

  // Full match when the cell at the pattern's end hits; empty pattern matches at once
  assign found     = (shift & (|(hit & tail))) | (search_live & (len == '0));
  assign found_pos = (len == '0) ? pos : (pos + POS_W'(1) - POS_W'(len));

  // Result selection
  always_comb begin
    emit    = 1'b0;
    res_new = '0;
    if (is_load & cmd.is_last & ovf_new) begin
      emit           = 1'b1;
      res_new.status = fosm_pkg::STATUS_OVERFLOW;
    end else if (is_text & ovf & cmd.is_last) begin
      emit           = 1'b1;
      res_new.status = fosm_pkg::STATUS_OVERFLOW;
    end else if (found) begin
      emit                   = 1'b1;
      res_new.status         = fosm_pkg::STATUS_FOUND;
      res_new.match_position = found_pos;
    end else if (is_text & ~ovf & ~done & cmd.is_last) begin
      emit           = 1'b1;
      res_new.status = fosm_pkg::STATUS_NONE;
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      closed <= 1'b1;
      ovf    <= 1'b0;
      pos    <= '0;
      done   <= 1'b0;
    end else begin
      if (is_load) begin
        len    <= has_room ? eff_len + LEN_W'(1) : eff_len;
        ovf    <= ovf_new;
        closed <= cmd.is_last;
      end
      if (clear) begin
        pos  <= '0;
        done <= 1'b0;
      end else if (is_text & ~ovf) begin
        pos <= pos + POS_W'(1);
        if (found) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_new;
    end
  end

  `FOSM_ASSERT_NXT(a_emit_shows, emit, res_valid)
  `FOSM_ASSERT_IMP(a_len_bound, 1'b1, len <= LEN_W'(PATTERN_MAX))
  `FOSM_ASSERT_IMP(a_ovf_full, ovf, len == LEN_W'(PATTERN_MAX))
  `FOSM_ASSERT_IMP(a_done_quiet, done & ~clear, ~found)

endmodule
